/* src/dvru_pkg.sv */
// Shared types and constants of the distance-vector route update block.
package dvru_pkg;

  // Field widths fixed by the item format.
  localparam int ID_BITS        = 6;
  localparam int PORT_DIST_BITS = 16;
  localparam int STATUS_BITS    = 3;

  // Defaults of the top-level parameters.
  localparam int NODE_COUNT_DEF = 64;
  localparam int DIST_BITS_DEF  = 16;

  // Operation carried by an input item.
  typedef enum logic {
    OP_INSTALL = 1'b0,
    OP_ADVERT  = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_UNCHANGED      = 3'd0,
    ST_INSERTED       = 3'd1,
    ST_IMPROVED       = 3'd2,
    ST_OWN_SKIP       = 3'd3,
    ST_UNKNOWN_SENDER = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the item and start the table reads
    logic exec;  // update the table and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;  // the result register still holds an untaken item
  } dp_status_t;

endpackage

/* src/dvru_ram.sv */
// Generic RAM with one write port and two registered read ports.
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

/* src/dvru_ctrl.sv */
// Controller state machine of the route update block.
module dvru_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dvru_pkg::dp_status_t  status_i,
  output dvru_pkg::ctrl_cmd_t   cmd_o
);
  import dvru_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!status_i.out_stall) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = !status_i.out_stall;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/dvru_datapath.sv */
// Datapath: routing table, relaxation arithmetic and result register.
module dvru_datapath #(
  parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF,
  parameter int DIST_BITS  = dvru_pkg::DIST_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dvru_pkg::ctrl_cmd_t                  cmd_i,
  output dvru_pkg::dp_status_t                 status_o,
  input  logic                                 cfg_we_i,
  input  logic [dvru_pkg::ID_BITS-1:0]         cfg_wdata_i,
  input  logic                                 opcode_i,
  input  logic [dvru_pkg::ID_BITS-1:0]         sender_id_i,
  input  logic [dvru_pkg::ID_BITS-1:0]         dest_id_i,
  input  logic [dvru_pkg::PORT_DIST_BITS-1:0]  distance_i,
  input  logic                                 last_of_message_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dvru_pkg::STATUS_BITS-1:0]     route_status_o,
  output logic [dvru_pkg::PORT_DIST_BITS-1:0]  new_distance_o,
  output logic [dvru_pkg::ID_BITS-1:0]         new_next_hop_o,
  output logic                                 message_changed_o
);
  import dvru_pkg::*;

  // Only ids that fit the id field can ever reach the table.
  localparam int TABLE_DEPTH = (NODE_COUNT < (2 ** ID_BITS)) ? NODE_COUNT : (2 ** ID_BITS);
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int WORD_BITS   = DIST_BITS + ID_BITS;

  // Configuration and item registers.
  logic [ID_BITS-1:0]   self_q;
  logic                 op_q;
  logic [ID_BITS-1:0]   sender_q;
  logic [ID_BITS-1:0]   dest_q;
  logic [DIST_BITS-1:0] dist_q;
  logic                 last_q;

  // Table state held in flops.
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   changed_q;

  // Result register.
  logic                      out_valid_q;
  status_e                   res_status_q;
  logic [DIST_BITS-1:0]      res_dist_q;
  logic [ID_BITS-1:0]        res_hop_q;
  logic                      res_flag_q;

  // Table memory.
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] sender_word;
  logic [WORD_BITS-1:0] dest_word;

  dvru_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (wr_en),
    .waddr_i  (dest_q[AW-1:0]),
    .wdata_i  (wr_word),
    .re_i     (cmd_i.load),
    .raddr_a_i(sender_id_i[AW-1:0]),
    .raddr_b_i(dest_id_i[AW-1:0]),
    .rdata_a_o(sender_word),
    .rdata_b_o(dest_word)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0;
    end else if (cfg_we_i) begin
      self_q <= cfg_wdata_i;
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      sender_q <= sender_id_i;
      dest_q   <= dest_id_i;
      dist_q   <= DIST_BITS'(distance_i);
      last_q   <= last_of_message_i;
    end
  end

  // Relaxation step.
  logic                 dest_in, sender_in;
  logic                 dest_vld, sender_vld;
  logic [DIST_BITS-1:0] dest_dist, sender_dist;
  logic [ID_BITS-1:0]   dest_hop;
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] cand;
  logic [DIST_BITS-1:0] wr_dist;
  logic [ID_BITS-1:0]   wr_hop;
  logic                 changed;
  status_e              status;
  logic                 flag;
  logic                 changed_d;
  logic [DIST_BITS-1:0] res_dist;
  logic [ID_BITS-1:0]   res_hop;

  always_comb begin
    dest_in     = (32'(dest_q) < TABLE_DEPTH);
    sender_in   = (32'(sender_q) < TABLE_DEPTH);
    dest_vld    = dest_in && valid_q[dest_q[AW-1:0]];
    sender_vld  = sender_in && valid_q[sender_q[AW-1:0]];
    dest_dist   = dest_word[DIST_BITS-1:0];
    dest_hop    = dest_word[WORD_BITS-1:DIST_BITS];
    sender_dist = sender_word[DIST_BITS-1:0];

    // Saturating sum of the sender's distance and the advertised distance.
    sum  = {1'b0, sender_dist} + {1'b0, dist_q};
    cand = sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];

    wr_en     = 1'b0;
    wr_dist   = dist_q;
    wr_hop    = dest_q;
    changed   = 1'b0;
    status    = ST_UNCHANGED;
    flag      = 1'b0;
    changed_d = changed_q;

    if (op_q == OP_INSTALL) begin
      // Direct neighbor: the next hop is the neighbor itself.
      if (dest_in) begin
        wr_en = 1'b1;
        if (!dest_vld) begin
          status = ST_INSERTED;
        end else if (dest_dist != dist_q || dest_hop != dest_q) begin
          status = ST_IMPROVED;
        end
      end
    end else begin
      wr_dist = cand;
      wr_hop  = sender_q;
      if (dest_q == self_q) begin
        status = ST_OWN_SKIP;
      end else if (!sender_vld) begin
        status = ST_UNKNOWN_SENDER;
      end else if (dest_in) begin
        if (!dest_vld) begin
          wr_en   = 1'b1;
          changed = 1'b1;
          status  = ST_INSERTED;
        end else if (cand < dest_dist) begin
          wr_en   = 1'b1;
          changed = 1'b1;
          status  = ST_IMPROVED;
        end
      end
      // The change flag is reported and cleared on the last entry of a message.
      if (last_q) begin
        flag      = changed_q | changed;
        changed_d = 1'b0;
      end else begin
        changed_d = changed_q | changed;
      end
    end

    wr_word = {wr_hop, wr_dist};

    // Stored entry of the destination after this step.
    if (wr_en) begin
      res_dist = wr_dist;
      res_hop  = wr_hop;
    end else if (dest_vld) begin
      res_dist = dest_dist;
      res_hop  = dest_hop;
    end else begin
      res_dist = '0;
      res_hop  = '0;
    end

    // Gate the write with the execute command.
    wr_en = wr_en & cmd_i.exec;
  end

  // Valid marks and the message change flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      changed_q <= 1'b0;
    end else if (cmd_i.exec) begin
      changed_q <= changed_d;
      if (wr_en) begin
        valid_q[dest_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Result register handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= status;
      res_dist_q   <= res_dist;
      res_hop_q    <= res_hop;
      res_flag_q   <= flag;
    end
  end

  assign status_o.out_stall = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign route_status_o     = res_status_q;
  assign new_distance_o     = PORT_DIST_BITS'(res_dist_q);
  assign new_next_hop_o     = res_hop_q;
  assign message_changed_o  = res_flag_q;

endmodule

/* src/distance_vector_route_update.sv */
// Top level of the distance-vector route update block.
//
// Keeps a routing table (valid mark, distance, next hop) for every node id and
// applies one install or advertised entry per input item, returning one result
// item for each. For each item the accept cycle starts the registered read of the
// sender's and the destination's table words from the two read ports of the table
// memory, and the next cycle adds, compares, writes back and loads the result
// register. A result that has not been taken holds the execute step of the
// following item until the result register frees. Valid marks sit in flip-flops
// cleared by reset, so no clearing pass is needed after reset.
module distance_vector_route_update #(
  parameter int NODE_COUNT = dvru_pkg::NODE_COUNT_DEF,
  parameter int DIST_BITS  = dvru_pkg::DIST_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dvru_pkg::ID_BITS-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 opcode_i,
  input  logic [dvru_pkg::ID_BITS-1:0]         sender_id_i,
  input  logic [dvru_pkg::ID_BITS-1:0]         dest_id_i,
  input  logic [dvru_pkg::PORT_DIST_BITS-1:0]  distance_i,
  input  logic                                 last_of_message_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dvru_pkg::STATUS_BITS-1:0]     status_o,
  output logic [dvru_pkg::PORT_DIST_BITS-1:0]  new_distance_o,
  output logic [dvru_pkg::ID_BITS-1:0]         new_next_hop_o,
  output logic                                 message_changed_o
);
  import dvru_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Controller.
  dvru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (dp_status),
    .cmd_o     (cmd)
  );

  // Datapath.
  dvru_datapath #(
    .NODE_COUNT(NODE_COUNT),
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .sender_id_i      (sender_id_i),
    .dest_id_i        (dest_id_i),
    .distance_i       (distance_i),
    .last_of_message_i(last_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .route_status_o   (status_o),
    .new_distance_o   (new_distance_o),
    .new_next_hop_o   (new_next_hop_o),
    .message_changed_o(message_changed_o)
  );

endmodule

/* test/distance_vector_route_update_tb.sv */
// Self-checking testbench for the distance-vector route update block.
`timescale 1ns / 1ps

module distance_vector_route_update_tb;
  import dvru_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int DIST_W         = DIST_BITS_DEF;
  localparam logic [PORT_DIST_BITS:0] DIST_LIMIT = (17'd1 << DIST_W) - 17'd1;

  // One table update request as it crosses the input channel.
  typedef struct packed {
    op_e                       op;
    logic [ID_BITS-1:0]        sender;
    logic [ID_BITS-1:0]        dest;
    logic [PORT_DIST_BITS-1:0] cost;
    logic                      last_entry;
  } route_item_t;

  // One result item as it leaves the block.
  typedef struct packed {
    status_e                   status;
    logic [PORT_DIST_BITS-1:0] new_dist;
    logic [ID_BITS-1:0]        hop;
    logic                      msg_changed;
  } route_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [ID_BITS-1:0]        cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      opcode_i;
  logic [ID_BITS-1:0]        sender_id_i;
  logic [ID_BITS-1:0]        dest_id_i;
  logic [PORT_DIST_BITS-1:0] distance_i;
  logic                      last_of_message_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [STATUS_BITS-1:0]    status_o;
  logic [PORT_DIST_BITS-1:0] new_distance_o;
  logic [ID_BITS-1:0]        new_next_hop_o;
  logic                      message_changed_o;

  // Shadow routing table and message flag of the predictor.
  logic                      route_valid [NODE_COUNT_DEF];
  logic [PORT_DIST_BITS-1:0] route_dist  [NODE_COUNT_DEF];
  logic [ID_BITS-1:0]        route_hop   [NODE_COUNT_DEF];
  logic                      msg_acc;
  logic [ID_BITS-1:0]        self_id;

  route_result_t pending_routes[$];

  // Stimulus pacing and bookkeeping.
  int  tx_burst_left;
  bit  tx_steady;
  int  rx_mode;
  bit  rx_hold_req;
  int  rx_hold_left;
  logic [15:0] rx_pattern;
  int  idle_cycles;
  int  mismatches;
  int  items_sent;
  int  results_checked;
  int  installs_sent;
  int  self_settings;
  int  changed_messages;
  int  status_seen [5];

  distance_vector_route_update i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .sender_id_i       (sender_id_i),
    .dest_id_i         (dest_id_i),
    .distance_i        (distance_i),
    .last_of_message_i (last_of_message_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .new_distance_o    (new_distance_o),
    .new_next_hop_o    (new_next_hop_o),
    .message_changed_o (message_changed_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Applies one item to the shadow table and returns the result it must give.
  function automatic route_result_t predict_route_update(input route_item_t it);
    route_result_t             r;
    logic [PORT_DIST_BITS:0]   sum;
    logic [PORT_DIST_BITS-1:0] dist_in;
    logic                      grew;
    r.status      = ST_UNCHANGED;
    r.msg_changed = 1'b0;
    grew          = 1'b0;
    dist_in       = it.cost & DIST_LIMIT[PORT_DIST_BITS-1:0];
    if (it.op == OP_INSTALL) begin
      if (!route_valid[it.dest]) begin
        r.status = ST_INSERTED;
      end else if (route_dist[it.dest] != dist_in || route_hop[it.dest] != it.dest) begin
        r.status = ST_IMPROVED;
      end
      route_valid[it.dest] = 1'b1;
      route_dist[it.dest]  = dist_in;
      route_hop[it.dest]   = it.dest;
    end else begin
      if (it.dest == self_id) begin
        r.status = ST_OWN_SKIP;
      end else if (!route_valid[it.sender]) begin
        r.status = ST_UNKNOWN_SENDER;
      end else begin
        // Relaxation through the sender, saturating at the largest distance.
        sum = {1'b0, route_dist[it.sender]} + {1'b0, dist_in};
        if (sum > DIST_LIMIT) sum = DIST_LIMIT;
        if (!route_valid[it.dest]) begin
          route_valid[it.dest] = 1'b1;
          route_dist[it.dest]  = sum[PORT_DIST_BITS-1:0];
          route_hop[it.dest]   = it.sender;
          r.status = ST_INSERTED;
          grew     = 1'b1;
        end else if (sum < {1'b0, route_dist[it.dest]}) begin
          route_dist[it.dest] = sum[PORT_DIST_BITS-1:0];
          route_hop[it.dest]  = it.sender;
          r.status = ST_IMPROVED;
          grew     = 1'b1;
        end
      end
      msg_acc = msg_acc | grew;
      if (it.last_entry) begin
        r.msg_changed = msg_acc;
        msg_acc       = 1'b0;
      end
    end
    r.new_dist = route_valid[it.dest] ? route_dist[it.dest] : '0;
    r.hop      = route_valid[it.dest] ? route_hop[it.dest] : '0;
    return r;
  endfunction

  // Distance mix: near zero, near the top, small costs and full-range values.
  function automatic logic [PORT_DIST_BITS-1:0] pick_distance();
    case ($urandom_range(0, 5))
      0:       return PORT_DIST_BITS'($urandom_range(0, 3));
      1:       return PORT_DIST_BITS'(16'hFFFF - $urandom_range(0, 3));
      2, 3:    return PORT_DIST_BITS'($urandom_range(1, 300));
      default: return PORT_DIST_BITS'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // Offers one item, with bursts and random gaps, and records its expected result.
  task automatic send_item(input route_item_t it);
    route_result_t exp_r;
    int            gap;
    if (!tx_steady && tx_burst_left == 0) begin
      gap           = $urandom_range(1, 6);
      tx_burst_left = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    in_valid_i        <= 1'b1;
    opcode_i          <= it.op;
    sender_id_i       <= it.sender;
    dest_id_i         <= it.dest;
    distance_i        <= it.cost;
    last_of_message_i <= it.last_entry;
    do @(posedge clk_i); while (!in_ready_o);
    exp_r = predict_route_update(it);
    pending_routes.push_back(exp_r);
    items_sent++;
    status_seen[exp_r.status]++;
    if (it.op == OP_INSTALL) installs_sent++;
    if (exp_r.msg_changed) changed_messages++;
  endtask

  task automatic send_fields(input op_e op, input int sender, input int dest,
                             input int cost, input bit last_entry);
    route_item_t it;
    it.op         = op;
    it.sender     = ID_BITS'(sender);
    it.dest       = ID_BITS'(dest);
    it.cost       = PORT_DIST_BITS'(cost);
    it.last_entry = last_entry;
    send_item(it);
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_self_id(input logic [ID_BITS-1:0] id);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    self_id = id;
    self_settings++;
  endtask

  // Random traffic: mostly well-formed messages from known neighbors, some installs and noise.
  task automatic run_random_traffic(input int n_items, input int id_span);
    route_item_t        it;
    int                 sent;
    int                 next_switch;
    int                 pick;
    int                 len;
    int                 tries;
    logic [ID_BITS-1:0] from;
    sent        = 0;
    next_switch = 0;
    while (sent < n_items) begin
      if (sent >= next_switch) begin
        rx_mode     = $urandom_range(0, 2);
        tx_steady   = ($urandom_range(0, 3) == 0);
        next_switch = sent + 64;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        it.op         = OP_INSTALL;
        it.sender     = ID_BITS'($urandom_range(0, 63));
        it.dest       = ($urandom_range(0, 9) == 0) ? ID_BITS'($urandom_range(0, 63))
                                                    : ID_BITS'($urandom_range(0, id_span));
        it.cost       = pick_distance();
        it.last_entry = 1'($urandom_range(0, 1));
        send_item(it);
        sent++;
      end else if (pick < 85) begin
        // Prefer a sender that is already in the table.
        from  = ID_BITS'($urandom_range(0, id_span));
        tries = 0;
        while (!route_valid[from] && tries < 6 && $urandom_range(0, 9) != 0) begin
          from = ID_BITS'($urandom_range(0, id_span));
          tries++;
        end
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          it.op         = OP_ADVERT;
          it.sender     = from;
          it.dest       = ($urandom_range(0, 19) == 0) ? self_id
                                                       : ID_BITS'($urandom_range(0, id_span));
          it.cost       = pick_distance();
          it.last_entry = (k == len - 1);
          send_item(it);
          sent++;
        end
      end else begin
        it.op         = op_e'($urandom_range(0, 1));
        it.sender     = ID_BITS'($urandom_range(0, 63));
        it.dest       = ID_BITS'($urandom_range(0, 63));
        it.cost       = PORT_DIST_BITS'($urandom());
        it.last_entry = 1'($urandom_range(0, 1));
        send_item(it);
        sent++;
      end
    end
  endtask

  // Hand-picked items for every operation and every special case.
  task automatic test_directed();
    tx_steady = 1'b1;
    rx_mode   = 1;
    set_self_id(ID_BITS'(5));
    // Unknown sender and own destination on an empty table.
    send_fields(OP_ADVERT, 9, 20, 4, 1'b1);
    send_fields(OP_ADVERT, 9, 5, 4, 1'b1);
    // Install: insert, repeat without change, then change the cost.
    send_fields(OP_INSTALL, 0, 9, 10, 1'b0);
    send_fields(OP_INSTALL, 0, 9, 10, 1'b0);
    send_fields(OP_INSTALL, 63, 9, 12, 1'b1);
    // Installing the own id is allowed.
    send_fields(OP_INSTALL, 0, 5, 0, 1'b0);
    // Insert through a neighbor, then an equal cost that must not replace it.
    send_fields(OP_ADVERT, 9, 20, 100, 1'b0);
    send_fields(OP_ADVERT, 9, 20, 100, 1'b0);
    send_fields(OP_INSTALL, 0, 3, 1, 1'b0);
    // A cheaper path closes the message with a change.
    send_fields(OP_ADVERT, 3, 20, 50, 1'b1);
    send_fields(OP_ADVERT, 3, 20, 60, 1'b1);
    // Sender advertising itself never improves the route.
    send_fields(OP_ADVERT, 9, 9, 0, 1'b1);
    // Saturation at the largest distance.
    send_fields(OP_INSTALL, 0, 63, 16'hFFFF, 1'b0);
    send_fields(OP_ADVERT, 63, 40, 16'hFFFF, 1'b0);
    send_fields(OP_ADVERT, 63, 0, 0, 1'b1);
    send_fields(OP_INSTALL, 0, 0, 0, 1'b0);
    send_fields(OP_ADVERT, 0, 63, 0, 1'b1);
    // Skipped entries still close a message, with or without an earlier change.
    send_fields(OP_ADVERT, 12, 30, 7, 1'b1);
    send_fields(OP_ADVERT, 3, 41, 7, 1'b0);
    send_fields(OP_ADVERT, 3, 5, 7, 1'b1);
    // Install ignores the end marker and leaves the flag alone.
    send_fields(OP_ADVERT, 3, 42, 2, 1'b0);
    send_fields(OP_INSTALL, 0, 3, 0, 1'b1);
    send_fields(OP_ADVERT, 12, 43, 2, 1'b1);
    wait_results_done();
  endtask

  // Low self id with a small id span, so many entries start unknown.
  task automatic test_sparse_table();
    set_self_id('0);
    run_random_traffic(400, 15);
    wait_results_done();
  endtask

  task automatic test_growing_table();
    set_self_id('1);
    run_random_traffic(400, 31);
    wait_results_done();
  endtask

  task automatic test_full_range();
    set_self_id(ID_BITS'($urandom_range(1, 62)));
    run_random_traffic(400, 63);
    wait_results_done();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    set_self_id(ID_BITS'($urandom_range(0, 63)));
    rx_hold_req = 1'b1;
    run_random_traffic(200, 63);
    wait_results_done();
  endtask

  // The sender pauses until the block has drained, then a new self id applies.
  task automatic test_drain_pause();
    set_self_id(ID_BITS'($urandom_range(0, 63)));
    run_random_traffic(115, 63);
    wait_results_done();
    set_self_id(ID_BITS'($urandom_range(0, 63)));
    run_random_traffic(115, 63);
    wait_results_done();
  endtask

  // Result side: ready pattern, long hold-off and the comparison of each item.
  always @(posedge clk_i) begin
    route_result_t got;
    route_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status      = status_e'(status_o);
      got.new_dist    = new_distance_o;
      got.hop         = new_next_hop_o;
      got.msg_changed = message_changed_o;
      if (pending_routes.size() == 0) begin
        report_mismatch($sformatf("unexpected result: status %0d dist %0d hop %0d chg %0b",
                                  got.status, got.new_dist, got.hop, got.msg_changed));
      end else begin
        exp_r = pending_routes.pop_front();
        results_checked++;
        if (got.status !== exp_r.status || got.new_dist !== exp_r.new_dist ||
            got.hop !== exp_r.hop || got.msg_changed !== exp_r.msg_changed) begin
          report_mismatch($sformatf(
              "result %0d: expected status %0d dist %0d hop %0d chg %0b, got %0d %0d %0d %0b",
              results_checked, exp_r.status, exp_r.new_dist, exp_r.hop, exp_r.msg_changed,
              status_o, new_distance_o, new_next_hop_o, message_changed_o));
        end
      end
    end
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: begin
          out_ready_i <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
        default: out_ready_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("distance_vector_route_update: mismatch");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    opcode_i          <= OP_INSTALL;
    sender_id_i       <= '0;
    dest_id_i         <= '0;
    distance_i        <= '0;
    last_of_message_i <= 1'b0;
    out_ready_i       <= 1'b0;
    for (int i = 0; i < NODE_COUNT_DEF; i++) begin
      route_valid[i] = 1'b0;
      route_dist[i]  = '0;
      route_hop[i]   = '0;
    end
    msg_acc          = 1'b0;
    self_id          = '0;
    tx_burst_left    = 0;
    tx_steady        = 1'b1;
    rx_mode          = 0;
    rx_hold_req      = 1'b0;
    rx_hold_left     = 0;
    rx_pattern       = 16'b1011_0011_1110_0101;
    idle_cycles      = 0;
    mismatches       = 0;
    items_sent       = 0;
    results_checked  = 0;
    installs_sent    = 0;
    self_settings    = 0;
    changed_messages = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_sparse_table();
    test_growing_table();
    test_full_range();
    test_output_stall();
    test_drain_pause();

    wait_results_done();
    repeat (8) @(posedge clk_i);
    if (pending_routes.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_routes.size()));
    end

    $display("Ran %0d items (%0d installs) under %0d self id settings, %0d results checked.",
             items_sent, installs_sent, self_settings, results_checked);
    $display("Unchanged %0d, inserted %0d, improved %0d, own skip %0d, unknown sender %0d; %0d %s",
             status_seen[ST_UNCHANGED], status_seen[ST_INSERTED], status_seen[ST_IMPROVED],
             status_seen[ST_OWN_SKIP], status_seen[ST_UNKNOWN_SENDER], changed_messages,
             "messages ended with a change.");
    if (mismatches == 0) begin
      $display("distance_vector_route_update: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("distance_vector_route_update: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
src/dvru_pkg.sv
src/dvru_ram.sv
src/dvru_ctrl.sv
src/dvru_datapath.sv
src/distance_vector_route_update.sv
test/distance_vector_route_update_tb.sv
